>>> sv/rde_pkg.sv
package rde_pkg;

  localparam int RADIX_W = 5;
  localparam int DIGIT_W = 4;
  localparam int CHAR_W  = 7;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

  localparam logic [CHAR_W-1:0]  ASCII_DIGIT_BASE  = 7'd48;
  localparam logic [CHAR_W-1:0]  ASCII_LETTER_BASE = 7'd55;
  localparam logic [DIGIT_W-1:0] MAX_DEC_DIGIT     = 4'd9;
  localparam logic [CHAR_W-1:0]  ERR_CHAR          = 7'd0;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ERR  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_EMIT = 4'b1000
  } rde_state_t;

  function automatic logic [CHAR_W-1:0] dig_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {{(CHAR_W-DIGIT_W){1'b0}}, d};
    if (d > MAX_DEC_DIGIT) begin
      return dx + ASCII_LETTER_BASE;
    end
    return dx + ASCII_DIGIT_BASE;
  endfunction

endpackage

>>> sv/rde_if.sv
interface rde_in_if #(
  parameter int VALUE_WIDTH = 31
);
  import rde_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] value;
  logic [RADIX_W-1:0]     radix;

  modport source (output valid, output value, output radix, input ready);
  modport sink   (input valid, input value, input radix, output ready);
endinterface

interface rde_out_if;
  import rde_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] digit_char;
  logic              bad_radix;
  logic              last_digit;

  modport source (output valid, output digit_char, output bad_radix, output last_digit,
                  input ready);
  modport sink   (input valid, input digit_char, input bad_radix, input last_digit,
                  output ready);
endinterface

>>> sv/radix_digit_emitter.sv
// Channel  | Dir | Handshake     | Payload
// in_ch    | in  | valid / ready | value [VALUE_WIDTH], radix [5]
// out_ch   | out | valid / ready | digit_char [7], bad_radix, last_digit
//
// Each digit comes from a bit-serial restoring division by the radix, one quotient bit
// per cycle, with the digits pushed on a shift-register stack. All digits of an item are
// divided out before any is emitted, most significant digit first; a bad radix gives a
// single error result with bad_radix and last_digit set.
// Synchronous active-low reset clears the state machine and the output valid.
// A stalled output holds its item; a new item is taken while the last result waits.
module radix_digit_emitter #(
  parameter int VALUE_WIDTH = 31
) (
  input  logic     clk,
  input  logic     rst_n,
  rde_in_if.sink   in_ch,
  rde_out_if.source out_ch
);
  import rde_pkg::*;

  localparam int CNT_W  = $clog2(VALUE_WIDTH);
  localparam int DCNT_W = $clog2(VALUE_WIDTH + 1);

  rde_state_t state_r, state_nxt;

  logic [VALUE_WIDTH-1:0] val_r, val_nxt;
  logic [RADIX_W-1:0]     rdx_r, rdx_nxt;
  logic [DIGIT_W-1:0]     rem_r, rem_nxt;
  logic [CNT_W-1:0]       bit_cnt_r, bit_cnt_nxt;
  logic                   nz_r, nz_nxt;
  logic [DCNT_W-1:0]      dig_cnt_r, dig_cnt_nxt;
  logic [DIGIT_W-1:0]     stk_r [VALUE_WIDTH];
  logic [DIGIT_W-1:0]     stk_nxt [VALUE_WIDTH];

  logic                   out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]      out_char_r, out_char_nxt;
  logic                   out_bad_r, out_bad_nxt;
  logic                   out_last_r, out_last_nxt;

  logic [RADIX_W-1:0]     trial;
  logic [RADIX_W-1:0]     diff;
  logic                   ge;
  logic [DIGIT_W-1:0]     step_rem;
  logic                   slot_free;

  // one restoring division step: bring down the next dividend bit
  assign trial    = {rem_r, val_r[VALUE_WIDTH-1]};
  assign ge       = (trial >= rdx_r);
  assign diff     = trial - rdx_r;
  assign step_rem = ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];

  assign slot_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt     = state_r;
    val_nxt       = val_r;
    rdx_nxt       = rdx_r;
    rem_nxt       = rem_r;
    bit_cnt_nxt   = bit_cnt_r;
    nz_nxt        = nz_r;
    dig_cnt_nxt   = dig_cnt_r;
    stk_nxt       = stk_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_bad_nxt   = out_bad_r;
    out_last_nxt  = out_last_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          val_nxt     = in_ch.value;
          rdx_nxt     = in_ch.radix;
          rem_nxt     = '0;
          bit_cnt_nxt = '0;
          nz_nxt      = 1'b0;
          dig_cnt_nxt = '0;
          if (in_ch.radix < RADIX_MIN || in_ch.radix > RADIX_MAX) begin
            state_nxt = ST_ERR;
          end else begin
            state_nxt = ST_DIV;
          end
        end
      end
      ST_ERR: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = ERR_CHAR;
          out_bad_nxt   = 1'b1;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_DIV: begin
        rem_nxt     = step_rem;
        val_nxt     = {val_r[VALUE_WIDTH-2:0], ge};
        nz_nxt      = nz_r | ge;
        bit_cnt_nxt = bit_cnt_r + 1'b1;
        if (bit_cnt_r == CNT_W'(VALUE_WIDTH - 1)) begin
          // push the finished digit; the quotient stays in val for the next pass
          stk_nxt[0] = step_rem;
          for (int i = 1; i < VALUE_WIDTH; i++) begin
            stk_nxt[i] = stk_r[i-1];
          end
          dig_cnt_nxt = dig_cnt_r + 1'b1;
          if (nz_r || ge) begin
            rem_nxt     = '0;
            bit_cnt_nxt = '0;
            nz_nxt      = 1'b0;
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = dig_to_ascii(stk_r[0]);
          out_bad_nxt   = 1'b0;
          out_last_nxt  = (dig_cnt_r == DCNT_W'(1));
          for (int i = 0; i < VALUE_WIDTH - 1; i++) begin
            stk_nxt[i] = stk_r[i+1];
          end
          dig_cnt_nxt = dig_cnt_r - 1'b1;
          if (dig_cnt_r == DCNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r      <= val_nxt;
    rdx_r      <= rdx_nxt;
    rem_r      <= rem_nxt;
    bit_cnt_r  <= bit_cnt_nxt;
    nz_r       <= nz_nxt;
    dig_cnt_r  <= dig_cnt_nxt;
    stk_r      <= stk_nxt;
    out_char_r <= out_char_nxt;
    out_bad_r  <= out_bad_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.digit_char = out_char_r;
  assign out_ch.bad_radix  = out_bad_r;
  assign out_ch.last_digit = out_last_r;

endmodule

>>> sv/rde_checker.sv
module rde_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [rde_pkg::CHAR_W-1:0] out_digit_char,
  input logic                      out_bad_radix,
  input logic                      out_last_digit
);
  import rde_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_digit_char)
      && $stable(out_bad_radix) && $stable(out_last_digit))
    else $error("stalled result changed");

  a_bad_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_radix |-> out_last_digit && out_digit_char == ERR_CHAR)
    else $error("bad radix result malformed");

  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_bad_radix |->
      (out_digit_char >= 7'd48 && out_digit_char <= 7'd57) ||
      (out_digit_char >= 7'd65 && out_digit_char <= 7'd70))
    else $error("digit character out of range");

  // one item at a time: ready drops right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready held after accept");

endmodule

bind radix_digit_emitter rde_checker u_rde_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_digit_char (out_ch.digit_char),
  .out_bad_radix  (out_ch.bad_radix),
  .out_last_digit (out_ch.last_digit)
);
